// File: hdl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Types, codes and constants shared by the two-stack shared buffer files.
// ----------------------------------------------------------------------------
package tsb_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 9;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [COUNT_WIDTH-1:0] CAP_RESET = 9'd256;
   localparam logic                   CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ACT_PUSH_A = 2'd0,
      ACT_POP_A  = 2'd1,
      ACT_PUSH_B = 2'd2,
      ACT_POP_B  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FILL
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic fill;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_fill;
   } stat_type;

endpackage

// File: hdl/tsb_req_if.sv
// ----------------------------------------------------------------------------
// tsb_req_if
// Request channel: one push or pop item per handshake.
// ----------------------------------------------------------------------------
interface tsb_req_if import tsb_pkg::*; ();

   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic signed [VALUE_WIDTH-1:0] push_value;

   modport source (output valid, action, push_value, input ready);
   modport sink   (input valid, action, push_value, output ready);

endinterface

// File: hdl/tsb_rsp_if.sv
// ----------------------------------------------------------------------------
// tsb_rsp_if
// Response channel: status, popped value, both tops and both sizes.
// ----------------------------------------------------------------------------
interface tsb_rsp_if import tsb_pkg::*; ();

   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [VALUE_WIDTH-1:0] popped_value;
   logic signed [VALUE_WIDTH-1:0] top_a;
   logic                          top_a_valid;
   logic signed [VALUE_WIDTH-1:0] top_b;
   logic                          top_b_valid;
   logic [COUNT_WIDTH-1:0]        size_a;
   logic [COUNT_WIDTH-1:0]        size_b;

   modport source (output valid, status, popped_value, top_a, top_a_valid,
                   top_b, top_b_valid, size_a, size_b, input ready);
   modport sink   (input valid, status, popped_value, top_a, top_a_valid,
                   top_b, top_b_valid, size_a, size_b, output ready);

endinterface

// File: hdl/two_stacks_shared_buffer.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_buffer
// Two LIFO stacks in one shared memory; A grows up from entry 0, B grows
// down from the top entry in use.
// Sequence: a push, a failed pop or a pop emptying its stack is captured,
// then executed and responded; a successful pop leaving its stack non-empty
// also refills the new top by a memory read before it responds. Responding
// waits for a free response slot; a new item is accepted only after that.
// Reset: synchronous, clears both stacks and sets the capacity to 256.
// ----------------------------------------------------------------------------
module two_stacks_shared_buffer import tsb_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   tsb_req_if.sink                   req_chan,
   tsb_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [COUNT_WIDTH-1:0] cap_ff, cap_in;
   logic [COUNT_WIDTH-1:0] cap_eff;
   logic                   cfg_clear;
   logic                   cap_sel;
   cmd_type                cmd;
   stat_type               stat;

   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_CAPACITY);
   assign cfg_clear  = csr_psel && csr_penable && csr_pwrite && cap_sel;
   assign cap_in     = cfg_clear ? csr_pwdata[COUNT_WIDTH-1:0] : cap_ff;
   assign csr_prdata = cap_sel ? CSR_DATA_WIDTH'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = 9'd1;
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = COUNT_WIDTH'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   tsb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsb_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg_clear        (cfg_clear),
      .cap_eff          (cap_eff),
      .req_action       (req_chan.action),
      .req_push_value   (req_chan.push_value),
      .rsp_status       (rsp_chan.status),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_top_a        (rsp_chan.top_a),
      .rsp_top_a_valid  (rsp_chan.top_a_valid),
      .rsp_top_b        (rsp_chan.top_b),
      .rsp_top_b_valid  (rsp_chan.top_b_valid),
      .rsp_size_a       (rsp_chan.size_a),
      .rsp_size_b       (rsp_chan.size_b)
   );

endmodule

// File: hdl/tsb_datapath.sv
// ----------------------------------------------------------------------------
// tsb_datapath
// Shared memory, stack counts, cached tops and the response registers.
// ----------------------------------------------------------------------------
module tsb_datapath import tsb_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic                          cfg_clear,
   input  logic [COUNT_WIDTH-1:0]        cap_eff,
   input  logic [1:0]                    req_action,
   input  logic signed [VALUE_WIDTH-1:0] req_push_value,
   output logic [1:0]                    rsp_status,
   output logic signed [VALUE_WIDTH-1:0] rsp_popped_value,
   output logic signed [VALUE_WIDTH-1:0] rsp_top_a,
   output logic                          rsp_top_a_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_top_b,
   output logic                          rsp_top_b_valid,
   output logic [COUNT_WIDTH-1:0]        rsp_size_a,
   output logic [COUNT_WIDTH-1:0]        rsp_size_b
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_WIDTH-1:0]  shared_mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0]  rdata_ff;

   action_type             act_ff, act_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [COUNT_WIDTH-1:0] count_a_ff, count_a_in;
   logic [COUNT_WIDTH-1:0] count_b_ff, count_b_in;
   logic [DATA_WIDTH-1:0]  top_a_ff, top_a_in;
   logic [DATA_WIDTH-1:0]  top_b_ff, top_b_in;
   status_type             status_ff, status_in;
   logic [DATA_WIDTH-1:0]  popped_ff, popped_in;

   logic [1:0]             rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_popped_ff, rsp_top_a_ff, rsp_top_b_ff;
   logic                   rsp_top_a_valid_ff, rsp_top_b_valid_ff;
   logic [COUNT_WIDTH-1:0] rsp_size_a_ff, rsp_size_b_ff;

   logic                   full;
   status_type             op_status;
   logic                   op_pop_ok;
   logic                   op_wr;
   logic                   op_rd;
   logic [COUNT_WIDTH-1:0] op_waddr, op_raddr;
   logic                   wr_en, rd_en;

   assign full = ({1'b0, count_a_ff} + {1'b0, count_b_ff}) >= {1'b0, cap_eff};

   always_comb begin
      op_status = STAT_OK;
      op_pop_ok = 1'b0;
      op_wr     = 1'b0;
      op_rd     = 1'b0;
      op_waddr  = count_a_ff;
      op_raddr  = count_a_ff - 9'd2;
      unique case (act_ff)
         ACT_PUSH_A: begin
            if (full) begin
               op_status = STAT_FULL;
            end else begin
               op_wr = 1'b1;
            end
         end
         ACT_POP_A: begin
            if (count_a_ff == '0) begin
               op_status = STAT_EMPTY;
            end else begin
               op_pop_ok = 1'b1;
               op_rd     = (count_a_ff != 9'd1);
            end
         end
         ACT_PUSH_B: begin
            op_waddr = cap_eff - 9'd1 - count_b_ff;
            if (full) begin
               op_status = STAT_FULL;
            end else begin
               op_wr = 1'b1;
            end
         end
         ACT_POP_B: begin
            op_raddr = cap_eff - count_b_ff + 9'd1;
            if (count_b_ff == '0) begin
               op_status = STAT_EMPTY;
            end else begin
               op_pop_ok = 1'b1;
               op_rd     = (count_b_ff != 9'd1);
            end
         end
         default: begin
            op_status = STAT_OK;
         end
      endcase
   end

   assign stat.need_fill = op_rd;
   assign wr_en = cmd.exec && op_wr;
   assign rd_en = cmd.exec && op_rd;

   always_comb begin
      act_in     = act_ff;
      val_in     = val_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      top_a_in   = top_a_ff;
      top_b_in   = top_b_ff;
      status_in  = status_ff;
      popped_in  = popped_ff;
      if (cmd.capture) begin
         act_in = action_type'(req_action);
         val_in = DATA_WIDTH'($unsigned(req_push_value));
      end
      if (cmd.exec) begin
         status_in = op_status;
         popped_in = '0;
         priority if (op_wr && (act_ff == ACT_PUSH_A)) begin
            count_a_in = count_a_ff + 9'd1;
            top_a_in   = val_ff;
         end else if (op_wr) begin
            count_b_in = count_b_ff + 9'd1;
            top_b_in   = val_ff;
         end else if (op_pop_ok && (act_ff == ACT_POP_A)) begin
            count_a_in = count_a_ff - 9'd1;
            popped_in  = top_a_ff;
         end else if (op_pop_ok) begin
            count_b_in = count_b_ff - 9'd1;
            popped_in  = top_b_ff;
         end else begin
            popped_in = '0;
         end
      end
      if (cmd.fill) begin
         if (act_ff == ACT_POP_A) begin
            top_a_in = rdata_ff;
         end else begin
            top_b_in = rdata_ff;
         end
      end
      if (cfg_clear) begin
         count_a_in = '0;
         count_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shared_mem_ff[AW'(op_waddr)] <= val_ff;
      end
      if (rd_en) begin
         rdata_ff <= shared_mem_ff[AW'(op_raddr)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      val_ff    <= val_in;
      top_a_ff  <= top_a_in;
      top_b_ff  <= top_b_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff      <= status_in;
         rsp_popped_ff      <= VALUE_WIDTH'(popped_in);
         rsp_top_a_valid_ff <= (count_a_in != '0);
         rsp_top_b_valid_ff <= (count_b_in != '0);
         rsp_top_a_ff       <= (count_a_in != '0) ? VALUE_WIDTH'(top_a_in) : '0;
         rsp_top_b_ff       <= (count_b_in != '0) ? VALUE_WIDTH'(top_b_in) : '0;
         rsp_size_a_ff      <= count_a_in;
         rsp_size_b_ff      <= count_b_in;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = $signed(rsp_popped_ff);
   assign rsp_top_a        = $signed(rsp_top_a_ff);
   assign rsp_top_a_valid  = rsp_top_a_valid_ff;
   assign rsp_top_b        = $signed(rsp_top_b_ff);
   assign rsp_top_b_valid  = rsp_top_b_valid_ff;
   assign rsp_size_a       = rsp_size_a_ff;
   assign rsp_size_b       = rsp_size_b_ff;

   a_counts_fit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_a_ff} + {1'b0, count_b_ff}) <= {1'b0, cap_eff})
      else $error("stack counts exceed capacity");

endmodule

// File: hdl/tsb_controller.sv
// ----------------------------------------------------------------------------
// tsb_controller
// Sequences one item: capture, execute, optional top refill, respond.
// ----------------------------------------------------------------------------
module tsb_controller import tsb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.need_fill) begin
               cmd.exec = 1'b1;
               state_in = S_FILL;
            end else if (slot_free) begin
               cmd.exec = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            if (slot_free) begin
               cmd.fill = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response emitted over a pending item");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted item not executed");

   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_FILL))
      else $error("refill entered without execute");

endmodule
